// ===== rtl/core/bse_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and command/status structs for the bubble sort engine.
// Used by bse_datapath, bse_ctrl and bubble_sort_engine; depends on nothing.
package bse_pkg;

  // Storage size and derived widths.
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the accepted item, or note it as dropped
    logic sort_init;   // set the pass length to the element count
    logic pass_start;  // start a pass: read entry 0, clear the swap flag
    logic carry_load;  // take entry 0 into the carry, read entry 1
    logic cmp;         // one compare-and-swap step along the pass
    logic pass_end;    // write the carry to the end of the pass
    logic emit_load;   // move the read entry into the output register
    logic set_clear;   // the set is done: clear count and overflow
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass_short;  // fewer than two entries left to sort
    logic cmp_last;    // this compare is the last of the pass
    logic swapped;     // the current pass has made a swap
    logic emit_last;   // the entry being emitted is the final one
    logic out_free;    // the output register can take an item
  } status_t;

endpackage

// ===== rtl/core/bse_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the bubble sort engine: element store, carry register, counters
// and the output register. Depends on bse_pkg; driven by bse_ctrl commands.
module bse_datapath (
  input  logic              clk,
  input  logic              rst,
  input  bse_pkg::cmd_t     cmd,
  output bse_pkg::status_t  status,
  input  bse_pkg::data_t    s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  output bse_pkg::data_t    m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);

  bse_pkg::data_t mem [bse_pkg::DEPTH];
  bse_pkg::data_t rdata;
  bse_pkg::data_t carry;
  bse_pkg::cnt_t  count;
  bse_pkg::cnt_t  m;
  bse_pkg::addr_t k;
  bse_pkg::addr_t e;
  logic           dropped;
  logic           swapped;

  bse_pkg::addr_t raddr;
  bse_pkg::addr_t waddr;
  bse_pkg::data_t wdata;
  logic           we;
  logic           not_full;
  logic           gt;
  bse_pkg::cnt_t  m_minus1;

  assign not_full = count < bse_pkg::DEPTH_CNT;
  assign gt       = carry > rdata;
  assign m_minus1 = m - bse_pkg::cnt_t'(1);

  // Read address: the pass walks ahead of the write by two entries.
  always_comb begin
    if (cmd.pass_start) begin
      raddr = '0;
    end else if (cmd.carry_load) begin
      raddr = k + bse_pkg::addr_t'(1);
    end else if (cmd.cmp) begin
      raddr = k + bse_pkg::addr_t'(2);
    end else begin
      raddr = e;
    end
  end

  // Write port: loading, the smaller value of a compare, or the carry at pass end.
  always_comb begin
    we    = 1'b0;
    waddr = e;
    wdata = carry;
    if (cmd.load && not_full) begin
      we    = 1'b1;
      waddr = count[bse_pkg::ADDR_W-1:0];
      wdata = s_tdata;
    end else if (cmd.cmp) begin
      we    = 1'b1;
      waddr = k;
      wdata = gt ? rdata : carry;
    end else if (cmd.pass_end) begin
      we    = 1'b1;
      waddr = m_minus1[bse_pkg::ADDR_W-1:0];
      wdata = carry;
    end
  end

  // Element store with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Count and overflow flag of the set being collected.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.set_clear) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (not_full) begin
        count <= count + bse_pkg::cnt_t'(1);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  // Pass length, pass position, carry and swap flag.
  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      m <= count;
      e <= '0;
    end
    if (cmd.pass_start) begin
      k       <= '0;
      swapped <= 1'b0;
    end
    if (cmd.carry_load) begin
      carry <= rdata;
    end
    if (cmd.cmp) begin
      k <= k + bse_pkg::addr_t'(1);
      if (gt) begin
        swapped <= 1'b1;
      end else begin
        carry <= rdata;
      end
    end
    if (cmd.pass_end) begin
      m <= m_minus1;
    end
    if (cmd.emit_load) begin
      e <= e + bse_pkg::addr_t'(1);
    end
  end

  // Output register: the set can be closed while the final item waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      m_tdata <= rdata;
      m_tlast <= status.emit_last;
      m_tuser <= dropped;
    end
  end

  // Status back to the controller.
  assign status.pass_short = m < bse_pkg::cnt_t'(2);
  assign status.cmp_last   = (bse_pkg::cnt_t'(k) + bse_pkg::cnt_t'(2)) == m;
  assign status.swapped    = swapped;
  assign status.emit_last  = (bse_pkg::cnt_t'(e) + bse_pkg::cnt_t'(1)) == count;
  assign status.out_free   = !m_tvalid || m_tready;

  // The fill count never passes the store size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= bse_pkg::DEPTH_CNT)
    else $error("element count beyond store size");

  // A compare step always compares an entry inside the current pass.
  a_cmp_in_pass: assert property (@(posedge clk) disable iff (rst)
    cmd.cmp |-> ((bse_pkg::cnt_t'(k) + bse_pkg::cnt_t'(2)) <= m))
    else $error("compare step outside the pass");

  // The output register is only loaded when its item has gone or was never there.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (!m_tvalid || m_tready))
    else $error("output item overwritten before it was taken");

endmodule

// ===== rtl/core/bse_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the bubble sort engine: load, sort passes, emit.
// Depends on bse_pkg; commands bse_datapath and reads its status.
module bse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  input  bse_pkg::status_t  status,
  output bse_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INIT    = 3'd1;
  localparam logic [2:0] S_PASS    = 3'd2;
  localparam logic [2:0] S_CARRY   = 3'd3;
  localparam logic [2:0] S_CMP     = 3'd4;
  localparam logic [2:0] S_PEND    = 3'd5;
  localparam logic [2:0] S_EMIT_RD = 3'd6;
  localparam logic [2:0] S_EMIT_LD = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tlast) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.sort_init = 1'b1;
        state_next    = S_PASS;
      end
      S_PASS: begin
        if (status.pass_short) begin
          state_next = S_EMIT_RD;
        end else begin
          cmd.pass_start = 1'b1;
          state_next     = S_CARRY;
        end
      end
      S_CARRY: begin
        cmd.carry_load = 1'b1;
        state_next     = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (status.cmp_last) begin
          state_next = S_PEND;
        end
      end
      S_PEND: begin
        cmd.pass_end = 1'b1;
        // A pass without a swap leaves the store in order.
        state_next = status.swapped ? S_PASS : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            cmd.set_clear = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/bubble_sort_engine.sv =====
`timescale 1ns / 1ps
// Top level of the bubble sort engine: controller plus datapath.
// Depends on bse_pkg, bse_ctrl and bse_datapath.
//
// Usage: the slave stream carries one signed 32-bit value per item in s_tdata;
// s_tlast marks the item that closes the set. Up to 16 values are stored, one
// item a cycle. Values that arrive with the store full are dropped and the set
// is flagged as overflowed; the closing item closes the set either way.
// Once the set is closed, s_tready stays low while the store is sorted in place
// by bubble passes, each one entry shorter than the last; sorting stops after
// a pass without a swap. The master stream then gives the values in ascending
// order, each read from the store and then loaded into the output register,
// with m_tlast on the final one and m_tuser high on every item of an
// overflowed set. The store has a single read and a single write port.
// The final item sits in an output register, so the next set is accepted
// while it waits. When m_tready is low, emission simply pauses; nothing is lost.
// A synchronous reset empties the set and clears the overflow flag and the
// output valid; store contents are left as they are.
module bubble_sort_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  bse_pkg::data_t s_tdata,   // [31:0] value
  input  logic           s_tlast,
  output logic           m_tvalid,
  input  logic           m_tready,
  output bse_pkg::data_t m_tdata,   // [31:0] sorted_value
  output logic           m_tlast,
  output logic           m_tuser    // [0] overflow
);

  bse_pkg::cmd_t    cmd;
  bse_pkg::status_t status;

  // Sequencing of load, sort passes and emission.
  bse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Store, compare-and-swap and output register.
  bse_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== test/bubble_sort_engine_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bubble_sort_engine: streams sets of signed values in,
// predicts the sorted output of each set and checks every result item against it.
// Depends on bse_pkg and bubble_sort_engine.
module bubble_sort_engine_tb;

  localparam bse_pkg::data_t MAX_VAL = bse_pkg::data_t'(32'h7fff_ffff);
  localparam bse_pkg::data_t MIN_VAL = bse_pkg::data_t'(32'h8000_0000);

  // One predicted result item of a closed set.
  typedef struct packed {
    bse_pkg::data_t value;
    logic           last;
    logic           ovf;
  } sorted_item_t;

  // Receiver readiness patterns.
  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_HALF,
    READY_RARELY
  } ready_mode_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  bse_pkg::data_t s_tdata = '0;
  logic           s_tlast = 1'b0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  bse_pkg::data_t m_tdata;
  logic           m_tlast;
  logic           m_tuser;

  // Predictor state: values of the open set and its dropped marker.
  bse_pkg::data_t open_set[$];
  bit             open_dropped = 1'b0;
  sorted_item_t   expected_sorted[$];

  int errors = 0;
  int burst_left = 0;
  int hold_req = 0;

  bubble_sort_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  // Takes one accepted value into the open set; on the closing item sorts the
  // stored values and queues one expected result per stored value.
  function automatic void absorb_value(bse_pkg::data_t v, logic l);
    bse_pkg::data_t t;
    bit             swapped;
    int             n;
    sorted_item_t   r;
    if (open_set.size() < bse_pkg::DEPTH) begin
      open_set.push_back(v);
    end else begin
      open_dropped = 1'b1;
    end
    if (l) begin
      n = open_set.size();
      for (int p = 0; p < n - 1; p++) begin
        swapped = 1'b0;
        for (int k = 0; k + 1 < n - p; k++) begin
          if (open_set[k] > open_set[k+1]) begin
            t             = open_set[k];
            open_set[k]   = open_set[k+1];
            open_set[k+1] = t;
            swapped       = 1'b1;
          end
        end
        if (!swapped) break;
      end
      for (int k = 0; k < n; k++) begin
        r.value = open_set[k];
        r.last  = (k == n - 1);
        r.ovf   = open_dropped;
        expected_sorted.push_back(r);
      end
      open_set.delete();
      open_dropped = 1'b0;
    end
  endfunction

  // Offers one item, with bursts and random gaps, and waits for its handshake.
  task automatic send_item(input bse_pkg::data_t v, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    absorb_value(v, l);
  endtask

  // Sends a whole set, the final value flagged as last.
  task automatic send_set(input bse_pkg::data_t vals[$]);
    foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_sorted.size() != 0) @(posedge clk);
  endtask

  // Field extremes, zero and minus one in one set, then a single-value set.
  task automatic test_extremes();
    bse_pkg::data_t vals[$];
    vals = '{MAX_VAL, MIN_VAL, bse_pkg::data_t'(0), bse_pkg::data_t'(-1),
             bse_pkg::data_t'(1)};
    send_set(vals);
    vals = '{MIN_VAL};
    send_set(vals);
    wait_drained();
  endtask

  // Equal values must come out together and unharmed.
  task automatic test_equal_values();
    bse_pkg::data_t vals[$];
    vals = '{bse_pkg::data_t'(5), bse_pkg::data_t'(5), bse_pkg::data_t'(-5),
             bse_pkg::data_t'(5)};
    send_set(vals);
    wait_drained();
  endtask

  // Reverse order filling the store, with a non-closing and the closing item
  // arriving while the store is full.
  task automatic test_overflow_reverse();
    bse_pkg::data_t vals[$];
    for (int k = 0; k < bse_pkg::DEPTH + 2; k++) begin
      vals.push_back(bse_pkg::data_t'(100 - 13 * k));
    end
    send_set(vals);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering,
  // so the block stalls its input.
  task automatic test_backpressure();
    bse_pkg::data_t vals[$];
    hold_req = 400;
    for (int k = 0; k < bse_pkg::DEPTH; k++) vals.push_back(bse_pkg::data_t'($urandom));
    send_set(vals);
    vals.delete();
    for (int k = 0; k < 10; k++) vals.push_back(bse_pkg::data_t'($urandom));
    send_set(vals);
    wait_drained();
  endtask

  // Random sets of mixed sizes and shapes, some of them overflowing.
  task automatic test_random(input int items);
    bse_pkg::data_t vals[$];
    bse_pkg::data_t cur;
    int             sent;
    int             n;
    int             pick;
    int             shape;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) n = $urandom_range(1, 8);
      else if (pick < 8) n = $urandom_range(9, bse_pkg::DEPTH);
      else n = $urandom_range(bse_pkg::DEPTH + 1, bse_pkg::DEPTH + 6);
      shape = $urandom_range(0, 4);
      cur = bse_pkg::data_t'($urandom) >>> 4;
      vals.delete();
      for (int k = 0; k < n; k++) begin
        case (shape)
          0: vals.push_back(bse_pkg::data_t'($urandom));
          1: vals.push_back(bse_pkg::data_t'($urandom_range(0, 6)) - bse_pkg::data_t'(3));
          2: begin
            cur = cur + bse_pkg::data_t'($urandom_range(0, 100000));
            vals.push_back(cur);
          end
          3: begin
            cur = cur - bse_pkg::data_t'($urandom_range(0, 100000));
            vals.push_back(cur);
          end
          default: begin
            case ($urandom_range(0, 4))
              0: vals.push_back(MAX_VAL);
              1: vals.push_back(MIN_VAL);
              2: vals.push_back(bse_pkg::data_t'(0));
              3: vals.push_back(bse_pkg::data_t'(-1));
              default: vals.push_back(bse_pkg::data_t'($urandom));
            endcase
          end
        endcase
      end
      send_set(vals);
      sent += n;
      // Now and then the sender waits for the output to empty.
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // Receiver: readiness follows a changing pattern, with an occasional long hold.
  always @(posedge clk) begin : receiver
    static int          hold_left = 0;
    static int          pattern_left = 0;
    static ready_mode_t mode = READY_ALWAYS;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (pattern_left == 0) begin
      mode         = ready_mode_t'($urandom_range(0, 3));
      pattern_left = $urandom_range(10, 80);
    end
    pattern_left--;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (mode)
        READY_ALWAYS: m_tready <= 1'b1;
        READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
        READY_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
        default:      m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Result checker: each accepted item against the oldest expectation.
  always @(posedge clk) begin : result_check
    sorted_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_sorted.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d last %0b ovf %0b",
                 $time, m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        want = expected_sorted.pop_front();
        if (m_tdata !== want.value) begin
          $display("%0t: sorted_value mismatch, expected %0d, actual %0d",
                   $time, want.value, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: end_of_set mismatch, expected %0b, actual %0b",
                   $time, want.last, m_tlast);
          errors++;
        end
        if (m_tuser !== want.ovf) begin
          $display("%0t: overflow mismatch, expected %0b, actual %0b",
                   $time, want.ovf, m_tuser);
          errors++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_equal_values();
    test_overflow_reverse();
    test_backpressure();
    test_random(200);
    // Give any stray result time to show up.
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_sorted.size() == 0) begin
      $display("bubble_sort_engine verification clean");
    end else begin
      $display("bubble_sort_engine verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("%0t: timeout", $time);
    $display("bubble_sort_engine verification failed");
    $finish;
  end

endmodule

// ===== bubble_sort_engine.f =====
rtl/core/bse_pkg.sv
rtl/core/bse_datapath.sv
rtl/core/bse_ctrl.sv
rtl/core/bubble_sort_engine.sv
test/bubble_sort_engine_tb.sv
